[rtl/timed_multi_port_queue_server_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the timed multi-port queue server
// Shared property forms. Each use expects ports named clock and reset.
// ----------------------------------------------------------------------------
`ifndef TIMED_MULTI_PORT_QUEUE_SERVER_CORE_MACROS_SVH
`define TIMED_MULTI_PORT_QUEUE_SERVER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TMQS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TMQS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/tmqs_pkg.sv]
// ----------------------------------------------------------------------------
// tmqs_pkg
// Shared types and constants of the timed multi-port queue server.
// ----------------------------------------------------------------------------
package tmqs_pkg;

   localparam int NUM_PORTS_DEF   = 4;
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int USER_W          = 16;
   localparam int TICK_W          = 16;
   localparam int REG_PORTS       = 4;
   localparam int PORT_NUM_W      = 3;
   localparam int SERVED_PORT_W   = 2;
   localparam int COUNT_W         = 3;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PORT_COUNT     = 3'd0,
      CSR_SERVICE_TIME_0 = 3'd1,
      CSR_SERVICE_TIME_1 = 3'd2,
      CSR_SERVICE_TIME_2 = 3'd3,
      CSR_SERVICE_TIME_3 = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      STAT_ENQUEUED = 2'd0,
      STAT_DROPPED  = 2'd1,
      STAT_SERVED   = 2'd2,
      STAT_IDLE     = 2'd3
   } status_type;

   typedef enum logic {
      REQ_ENQUEUE = 1'b0,
      REQ_DEQUEUE = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RELOAD,
      ST_SWEEP,
      ST_SUB,
      ST_SCAN,
      ST_EMIT
   } srv_state_type;

   // Commands from the sequencer to one port cell.
   typedef struct packed {
      logic reload;
      logic push;
      logic sub;
      logic pop;
   } cell_ctl_type;

   // Status of one port cell back to the sequencer.
   typedef struct packed {
      logic full;
      logic done;
   } cell_stat_type;

   // Running minimum handed from cell to cell.
   typedef struct packed {
      logic              any;
      logic [TICK_W-1:0] min;
   } min_link_type;

endpackage

[rtl/tmqs_store.sv]
// ----------------------------------------------------------------------------
// tmqs_store
// User id storage for all port queues: one write and one registered read port.
// ----------------------------------------------------------------------------
module tmqs_store #(
   parameter int WORDS = tmqs_pkg::NUM_PORTS_DEF * tmqs_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [$clog2(WORDS)-1:0]    wr_addr,
   input  logic [tmqs_pkg::USER_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [$clog2(WORDS)-1:0]    rd_addr,
   output logic [tmqs_pkg::USER_W-1:0] rd_data
);

   logic [tmqs_pkg::USER_W-1:0] mem_ff [WORDS];
   logic [tmqs_pkg::USER_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/tmqs_cell.sv]
// ----------------------------------------------------------------------------
// tmqs_cell
// One port: queue head and fill, countdown timer, and one stage of the
// minimum chain that runs along all ports.
// ----------------------------------------------------------------------------
`include "timed_multi_port_queue_server_core_macros.svh"

module tmqs_cell #(
   parameter int QUEUE_DEPTH = tmqs_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               active,
   input  logic [tmqs_pkg::TICK_W-1:0]        service_time,
   input  tmqs_pkg::cell_ctl_type             ctl,
   input  logic [tmqs_pkg::TICK_W-1:0]        step,
   input  tmqs_pkg::min_link_type             link_in,
   output tmqs_pkg::min_link_type             link_out,
   output tmqs_pkg::cell_stat_type            stat,
   output logic [$clog2(QUEUE_DEPTH)-1:0]     head,
   output logic [$clog2(QUEUE_DEPTH)-1:0]     tail
);

   localparam int HW = $clog2(QUEUE_DEPTH);
   localparam int FW = $clog2(QUEUE_DEPTH + 1);

   logic [HW-1:0]                 head_ff, head_in;
   logic [FW-1:0]                 fill_ff, fill_in;
   logic [tmqs_pkg::TICK_W-1:0]   rem_ff, rem_in;
   logic                          done_ff, done_in;
   tmqs_pkg::min_link_type        link_ff, link_in_next;
   logic                          nonempty;
   logic [HW:0]                   tail_sum;
   logic [tmqs_pkg::TICK_W-1:0]   reload_val;

   assign nonempty   = (fill_ff != '0);
   assign reload_val = (service_time == '0) ? tmqs_pkg::TICK_W'(1) : service_time;

   // The write slot is head plus fill, folded back once into the ring.
   assign tail_sum = (HW+1)'(head_ff) + (HW+1)'(fill_ff);
   assign tail     = (tail_sum >= (HW+1)'(QUEUE_DEPTH)) ?
                     HW'(tail_sum - (HW+1)'(QUEUE_DEPTH)) : HW'(tail_sum);
   assign head     = head_ff;

   assign stat.full = (fill_ff >= FW'(QUEUE_DEPTH));
   assign stat.done = done_ff;
   assign link_out  = link_ff;

   always_comb begin
      rem_in  = rem_ff;
      done_in = done_ff;
      head_in = head_ff;
      fill_in = fill_ff;
      if (ctl.reload && active && (rem_ff == '0)) begin
         rem_in = reload_val;
      end
      if (ctl.sub) begin
         done_in = 1'b0;
         if (active && nonempty) begin
            rem_in  = rem_ff - step;
            done_in = (rem_ff == step);
         end
      end
      if (ctl.push) begin
         fill_in = fill_ff + FW'(1);
      end
      if (ctl.pop) begin
         head_in = (head_ff == HW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + HW'(1);
         fill_in = fill_ff - FW'(1);
         done_in = 1'b0;
      end
   end

   // A busy port in use offers its timer to the running minimum.
   always_comb begin
      link_in_next = link_in;
      if (active && nonempty && (!link_in.any || (rem_ff < link_in.min))) begin
         link_in_next.any = 1'b1;
         link_in_next.min = rem_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
         rem_ff  <= '0;
         done_ff <= 1'b0;
         link_ff <= '0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
         rem_ff  <= rem_in;
         done_ff <= done_in;
         link_ff <= link_in_next;
      end
   end

   `TMQS_ASSERT_NOW(a_push_not_full, ctl.push, !stat.full, "push into a full queue")
   `TMQS_ASSERT_NOW(a_pop_not_empty, ctl.pop, nonempty && done_ff, "pop of an unserved port")
   `TMQS_ASSERT_NOW(a_sub_no_wrap, ctl.sub && active && nonempty, rem_ff >= step,
                    "time step larger than a busy timer")

endmodule

[rtl/timed_multi_port_queue_server_core.sv]
// ----------------------------------------------------------------------------
// timed_multi_port_queue_server_core
// Per-port user queues with service countdown timers. Enqueue words append a
// user to a port; dequeue words advance time to the next completions and
// return the users that leave, in port order.
// ----------------------------------------------------------------------------
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_type, req_user_id, req_port_number
//   rsp     | out       | rsp_valid/rsp_stall | status, served user/port, ticks, last
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// An enqueue's result is in the output register in the cycle after it is taken.
// A dequeue passes a reload state, a sweep in which the minimum ripples through
// the chain of port cells, a subtract state, then a scan step per port passed and
// a queue memory read, then output, per user served.
// Reset is synchronous and leaves every queue empty; the memory needs no clearing.
// A new word is taken only when the block is idle and the output register is
// empty or being emptied; a stalled result holds its register.
// ----------------------------------------------------------------------------
`include "timed_multi_port_queue_server_core_macros.svh"

module timed_multi_port_queue_server_core #(
   parameter int NUM_PORTS   = tmqs_pkg::NUM_PORTS_DEF,
   parameter int QUEUE_DEPTH = tmqs_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_type,
   input  logic [tmqs_pkg::USER_W-1:0]          req_user_id,
   input  logic [tmqs_pkg::PORT_NUM_W-1:0]      req_port_number,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_status,
   output logic [tmqs_pkg::USER_W-1:0]          rsp_served_user,
   output logic [tmqs_pkg::SERVED_PORT_W-1:0]   rsp_served_port,
   output logic [tmqs_pkg::TICK_W-1:0]          rsp_elapsed_ticks,
   output logic                                 rsp_last,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tmqs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tmqs_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int HW    = $clog2(QUEUE_DEPTH);
   localparam int WORDS = NUM_PORTS * QUEUE_DEPTH;
   localparam int AW    = $clog2(WORDS);
   localparam int PW    = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
   localparam int CW    = $clog2(NUM_PORTS + 1);
   localparam logic [tmqs_pkg::COUNT_W-1:0] CAP =
      tmqs_pkg::COUNT_W'((NUM_PORTS < tmqs_pkg::REG_PORTS) ? NUM_PORTS : tmqs_pkg::REG_PORTS);

   // Configuration registers.
   logic [tmqs_pkg::COUNT_W-1:0]   port_count_ff;
   logic [tmqs_pkg::TICK_W-1:0]    svc_ff [tmqs_pkg::REG_PORTS];
   logic [tmqs_pkg::COUNT_W-1:0]   n_eff;

   // Sequencer.
   tmqs_pkg::srv_state_type        state_ff, state_in;
   logic [PW-1:0]                  p_ff, p_in;
   logic [CW-1:0]                  cnt_ff, cnt_in;
   logic [tmqs_pkg::TICK_W-1:0]    step_ff, step_in;

   // Output register.
   logic                           rsp_valid_ff, rsp_valid_in;
   tmqs_pkg::status_type           rsp_status_ff, rsp_status_in;
   logic [tmqs_pkg::USER_W-1:0]    rsp_user_ff, rsp_user_in;
   logic [tmqs_pkg::SERVED_PORT_W-1:0] rsp_port_ff, rsp_port_in;
   logic [tmqs_pkg::TICK_W-1:0]    rsp_ticks_ff, rsp_ticks_in;
   logic                           rsp_last_ff, rsp_last_in;
   logic                           out_load;
   logic                           out_free;

   // Cell chain.
   tmqs_pkg::cell_ctl_type         ctl_a    [NUM_PORTS];
   tmqs_pkg::cell_stat_type        stat_a   [NUM_PORTS];
   tmqs_pkg::min_link_type         link_a   [NUM_PORTS+1];
   logic [HW-1:0]                  head_a   [NUM_PORTS];
   logic [HW-1:0]                  tail_a   [NUM_PORTS];
   logic [tmqs_pkg::TICK_W-1:0]    cell_svc [NUM_PORTS];
   logic [NUM_PORTS-1:0]           active_v;
   logic [NUM_PORTS-1:0]           done_v;
   tmqs_pkg::min_link_type         chain_end;

   // Queue memory.
   logic                           mem_we;
   logic [AW-1:0]                  mem_waddr;
   logic                           mem_re;
   logic [AW-1:0]                  mem_raddr;
   logic [tmqs_pkg::USER_W-1:0]    mem_rdata;

   logic                           req_fire;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         port_count_ff <= tmqs_pkg::COUNT_W'(4);
         for (int i = 0; i < tmqs_pkg::REG_PORTS; i++) begin
            svc_ff[i] <= tmqs_pkg::TICK_W'(1);
         end
      end else if (csr_valid && csr_ready) begin
         unique case (tmqs_pkg::csr_index_type'(csr_index))
            tmqs_pkg::CSR_PORT_COUNT:     port_count_ff <= csr_data[tmqs_pkg::COUNT_W-1:0];
            tmqs_pkg::CSR_SERVICE_TIME_0: svc_ff[0] <= csr_data;
            tmqs_pkg::CSR_SERVICE_TIME_1: svc_ff[1] <= csr_data;
            tmqs_pkg::CSR_SERVICE_TIME_2: svc_ff[2] <= csr_data;
            tmqs_pkg::CSR_SERVICE_TIME_3: svc_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   // Ports in use: the programmed count held between one and the port limit.
   assign n_eff = (port_count_ff == '0) ? tmqs_pkg::COUNT_W'(1) :
                  (port_count_ff > CAP) ? CAP : port_count_ff;

   assign link_a[0] = '0;
   assign chain_end = link_a[NUM_PORTS];

   for (genvar g = 0; g < NUM_PORTS; g++) begin : g_cell
      assign active_v[g] = (tmqs_pkg::COUNT_W'(g) < n_eff);
      assign done_v[g]   = stat_a[g].done;
      if (g < tmqs_pkg::REG_PORTS) begin : g_svc
         assign cell_svc[g] = svc_ff[g];
      end else begin : g_nosvc
         assign cell_svc[g] = tmqs_pkg::TICK_W'(1);
      end

      tmqs_cell #(
         .QUEUE_DEPTH (QUEUE_DEPTH)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .active       (active_v[g]),
         .service_time (cell_svc[g]),
         .ctl          (ctl_a[g]),
         .step         (chain_end.min),
         .link_in      (link_a[g]),
         .link_out     (link_a[g+1]),
         .stat         (stat_a[g]),
         .head         (head_a[g]),
         .tail         (tail_a[g])
      );
   end

   tmqs_store #(
      .WORDS (WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (req_user_id),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == tmqs_pkg::ST_IDLE) && out_free);
   assign req_fire  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tmqs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      logic [tmqs_pkg::PORT_NUM_W-1:0] idx;
      logic                            sel_full;
      logic [HW-1:0]                   sel_tail;
      logic                            more;

      state_in      = state_ff;
      p_in          = p_ff;
      cnt_in        = cnt_ff;
      step_in       = step_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_re        = 1'b0;
      mem_raddr     = '0;
      out_load      = 1'b0;
      rsp_status_in = tmqs_pkg::STAT_IDLE;
      rsp_user_in   = '0;
      rsp_port_in   = '0;
      rsp_ticks_in  = '0;
      rsp_last_in   = 1'b1;
      for (int i = 0; i < NUM_PORTS; i++) begin
         ctl_a[i] = '0;
      end

      idx      = req_port_number - tmqs_pkg::PORT_NUM_W'(1);
      sel_full = 1'b0;
      sel_tail = '0;
      for (int i = 0; i < NUM_PORTS; i++) begin
         if (tmqs_pkg::PORT_NUM_W'(i) == idx) begin
            sel_full = stat_a[i].full;
            sel_tail = tail_a[i];
         end
      end

      // Any port still to be served after the current one ends the burst later.
      more = 1'b0;
      for (int i = 0; i < NUM_PORTS; i++) begin
         if ((i > int'(p_ff)) && done_v[i]) begin
            more = 1'b1;
         end
      end

      unique case (state_ff)
         tmqs_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (tmqs_pkg::req_kind_type'(req_type) == tmqs_pkg::REQ_DEQUEUE) begin
                  state_in = tmqs_pkg::ST_RELOAD;
               end else begin
                  out_load = 1'b1;
                  if ((req_port_number == '0) ||
                      (tmqs_pkg::COUNT_W'(req_port_number) > n_eff) || sel_full) begin
                     rsp_status_in = tmqs_pkg::STAT_DROPPED;
                  end else begin
                     rsp_status_in = tmqs_pkg::STAT_ENQUEUED;
                     mem_we        = 1'b1;
                     mem_waddr     = AW'(int'(idx) * QUEUE_DEPTH) + AW'(sel_tail);
                     for (int i = 0; i < NUM_PORTS; i++) begin
                        ctl_a[i].push = (tmqs_pkg::PORT_NUM_W'(i) == idx);
                     end
                  end
               end
            end
         end
         tmqs_pkg::ST_RELOAD: begin
            for (int i = 0; i < NUM_PORTS; i++) begin
               ctl_a[i].reload = 1'b1;
            end
            cnt_in   = '0;
            state_in = tmqs_pkg::ST_SWEEP;
         end
         tmqs_pkg::ST_SWEEP: begin
            // The minimum moves one cell per cycle; it reaches the end after
            // one pass over all cells.
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(NUM_PORTS - 1)) begin
               state_in = tmqs_pkg::ST_SUB;
            end
         end
         tmqs_pkg::ST_SUB: begin
            if (chain_end.any) begin
               step_in = chain_end.min;
               for (int i = 0; i < NUM_PORTS; i++) begin
                  ctl_a[i].sub = 1'b1;
               end
               p_in     = '0;
               state_in = tmqs_pkg::ST_SCAN;
            end else begin
               out_load      = 1'b1;
               rsp_status_in = tmqs_pkg::STAT_IDLE;
               state_in      = tmqs_pkg::ST_IDLE;
            end
         end
         tmqs_pkg::ST_SCAN: begin
            if (done_v[p_ff]) begin
               mem_re    = 1'b1;
               mem_raddr = AW'(int'(p_ff) * QUEUE_DEPTH) + AW'(head_a[p_ff]);
               state_in  = tmqs_pkg::ST_EMIT;
            end else if (tmqs_pkg::COUNT_W'(p_ff) == (n_eff - tmqs_pkg::COUNT_W'(1))) begin
               state_in = tmqs_pkg::ST_IDLE;
            end else begin
               p_in = p_ff + PW'(1);
            end
         end
         tmqs_pkg::ST_EMIT: begin
            if (out_free) begin
               out_load         = 1'b1;
               rsp_status_in    = tmqs_pkg::STAT_SERVED;
               rsp_user_in      = mem_rdata;
               rsp_port_in      = tmqs_pkg::SERVED_PORT_W'(p_ff);
               rsp_ticks_in     = step_ff;
               rsp_last_in      = !more;
               ctl_a[p_ff].pop  = 1'b1;
               if (more) begin
                  p_in     = p_ff + PW'(1);
                  state_in = tmqs_pkg::ST_SCAN;
               end else begin
                  state_in = tmqs_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = tmqs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff   <= '0;
         cnt_ff <= '0;
      end else begin
         p_ff   <= p_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_user_ff   <= rsp_user_in;
         rsp_port_ff   <= rsp_port_in;
         rsp_ticks_ff  <= rsp_ticks_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_served_user   = rsp_user_ff;
   assign rsp_served_port   = rsp_port_ff;
   assign rsp_elapsed_ticks = rsp_ticks_ff;
   assign rsp_last          = rsp_last_ff;

   `TMQS_ASSERT_NOW(a_scan_in_range, state_ff == tmqs_pkg::ST_SCAN || state_ff == tmqs_pkg::ST_EMIT,
                    tmqs_pkg::COUNT_W'(p_ff) < n_eff, "port pointer beyond ports in use")
   `TMQS_ASSERT_NOW(a_emit_served_port, state_ff == tmqs_pkg::ST_EMIT, done_v[p_ff],
                    "emitting a port that finished nothing")
   `TMQS_ASSERT_NEXT(a_idle_result, state_ff == tmqs_pkg::ST_SUB && !chain_end.any,
                     rsp_valid_ff && rsp_status_ff == tmqs_pkg::STAT_IDLE && rsp_last_ff,
                     "idle dequeue gave no idle word")
   `TMQS_ASSERT_NEXT(a_sub_finds_done, state_ff == tmqs_pkg::ST_SUB && chain_end.any,
                     done_v != '0, "time step finished no port")

endmodule

[tb/tb_timed_multi_port_queue_server_core.sv]
// ----------------------------------------------------------------------------
// tb_timed_multi_port_queue_server_core
// Self-checking bench for the timed multi-port queue server. A bursty driver
// feeds enqueue and dequeue words, and a shadow of the per-port queues and
// timers works out the words each one must return. A monitor checks the
// returned words in order while the receive side stalls on shifting patterns.
// ----------------------------------------------------------------------------
module tb_timed_multi_port_queue_server_core;
   import tmqs_pkg::*;

   localparam int PORTS        = NUM_PORTS_DEF;
   localparam int DEPTH        = QUEUE_DEPTH_DEF;
   localparam int PORT_CAP     = (PORTS < REG_PORTS) ? PORTS : REG_PORTS;
   localparam int SETTLE       = 40;
   localparam int LIMIT_CYCLES = 200000;
   localparam int HOLD_CYCLES  = 300;
   localparam int PRINT_CAP    = 200;

   // Indexes with no register behind them; writes there must be ignored.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_FIRST = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_LAST  = 3'd7;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_HALF,
      STALL_QUARTER,
      STALL_TOGGLE
   } stall_pattern_type;

   typedef struct packed {
      req_kind_type                kind;
      logic [USER_W-1:0]           user;
      logic [PORT_NUM_W-1:0]       port;
   } server_req_type;

   typedef struct packed {
      status_type                  status;
      logic [USER_W-1:0]           user;
      logic [SERVED_PORT_W-1:0]    port;
      logic [TICK_W-1:0]           ticks;
      logic                        last;
   } server_word_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_type = REQ_ENQUEUE;
   logic [USER_W-1:0]           req_user_id = '0;
   logic [PORT_NUM_W-1:0]       req_port_number = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [1:0]                  rsp_status;
   logic [USER_W-1:0]           rsp_served_user;
   logic [SERVED_PORT_W-1:0]    rsp_served_port;
   logic [TICK_W-1:0]           rsp_elapsed_ticks;
   logic                        rsp_last;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]       csr_data = '0;

   // Shadow of the server: configuration, queues and countdown timers.
   logic [COUNT_W-1:0]          cfg_port_count;
   logic [TICK_W-1:0]           cfg_service [REG_PORTS];
   logic [USER_W-1:0]           waiting_ids [PORTS][DEPTH];
   int unsigned                 head_of [PORTS];
   int unsigned                 fill_of [PORTS];
   logic [TICK_W-1:0]           ticks_left [PORTS];

   server_req_type              queued_reqs [$];
   server_word_type             pending_outcomes [$];
   server_req_type              on_bus;
   server_word_type             oldest_word;
   int unsigned                 items_issued = 0;
   int unsigned                 items_taken = 0;
   int unsigned                 failures = 0;
   int unsigned                 burst_left = 1;
   int unsigned                 gap_left = 0;
   int unsigned                 cycle_count = 0;
   int unsigned                 hold_left = 0;
   int unsigned                 holds_done = 0;
   int unsigned                 mode_left = 0;
   stall_pattern_type           stall_mode = STALL_NONE;

   timed_multi_port_queue_server_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_user_id       (req_user_id),
      .req_port_number   (req_port_number),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_served_user   (rsp_served_user),
      .rsp_served_port   (rsp_served_port),
      .rsp_elapsed_ticks (rsp_elapsed_ticks),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #5 clock = ~clock;

   // The port count register is clamped to the ports that exist.
   function automatic int unsigned ports_in_use();
      int unsigned n;
      n = 32'(cfg_port_count);
      if (n < 1) n = 1;
      if (n > PORT_CAP) n = PORT_CAP;
      return n;
   endfunction

   // Updates the shadow for one accepted word and queues the words it returns.
   task automatic service_outcome(input server_req_type r);
      int unsigned     n;
      int unsigned     p;
      int unsigned     step;
      int unsigned     cnt;
      bit              any;
      server_word_type w;
      server_word_type served [PORTS];
      n = ports_in_use();
      w = '0;
      w.last = 1'b1;
      if (r.kind == REQ_ENQUEUE) begin
         w.status = STAT_DROPPED;
         if (r.port >= 1 && r.port <= n && fill_of[r.port - 1] < DEPTH) begin
            p = r.port - 1;
            waiting_ids[p][(head_of[p] + fill_of[p]) % DEPTH] = r.user;
            fill_of[p]++;
            w.status = STAT_ENQUEUED;
         end
         pending_outcomes.push_back(w);
      end else begin
         any = 1'b0;
         step = 0;
         cnt = 0;
         for (int i = 0; i < n; i++) begin
            if (ticks_left[i] == '0)
               ticks_left[i] = (cfg_service[i] == '0) ? TICK_W'(1) : cfg_service[i];
            if (fill_of[i] != 0) begin
               if (!any || 32'(ticks_left[i]) < step) step = 32'(ticks_left[i]);
               any = 1'b1;
            end
         end
         if (!any) begin
            w.status = STAT_IDLE;
            pending_outcomes.push_back(w);
         end else begin
            for (int i = 0; i < n; i++) begin
               if (fill_of[i] != 0) begin
                  ticks_left[i] = ticks_left[i] - TICK_W'(step);
                  if (ticks_left[i] == '0) begin
                     w.status = STAT_SERVED;
                     w.user   = waiting_ids[i][head_of[i]];
                     w.port   = SERVED_PORT_W'(i);
                     w.ticks  = TICK_W'(step);
                     w.last   = 1'b0;
                     head_of[i] = (head_of[i] + 1) % DEPTH;
                     fill_of[i]--;
                     served[cnt] = w;
                     cnt++;
                  end
               end
            end
            served[cnt - 1].last = 1'b1;
            for (int k = 0; k < cnt; k++) pending_outcomes.push_back(served[k]);
         end
      end
   endtask

   // Driver: bursts of words separated by random gaps; a stalled word holds.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            service_outcome(on_bus);
            items_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (queued_reqs.size() > 0) begin
               on_bus = queued_reqs.pop_front();
               req_valid       <= 1'b1;
               req_type        <= on_bus.kind;
               req_user_id     <= on_bus.user;
               req_port_number <= on_bus.port;
               if (burst_left <= 1) begin
                  burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receive side: shifting stall patterns, and twice a long hold-off while
   // the sender is still offering words, so that the block backs up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         cycle_count++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_valid && req_valid &&
                      ((holds_done == 0 && cycle_count >= 500) ||
                       (holds_done == 1 && cycle_count >= 2500))) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = stall_pattern_type'($urandom_range(0, 3));
               mode_left  = $urandom_range(10, 60);
            end else begin
               mode_left--;
            end
            case (stall_mode)
               STALL_NONE:    rsp_stall <= 1'b0;
               STALL_HALF:    rsp_stall <= 1'($urandom_range(0, 1));
               STALL_QUARTER: rsp_stall <= ($urandom_range(0, 3) == 0);
               default:       rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   task automatic check_field(input string name, input logic [USER_W-1:0] want,
                              input logic [USER_W-1:0] got);
      if (got !== want) begin
         failures++;
         if (failures <= PRINT_CAP)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // Monitor: every accepted result word is checked against the oldest one due.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            failures++;
            if (failures <= PRINT_CAP)
               $display("%0t: unexpected word, expected none, actual status %h user %h",
                        $time, rsp_status, rsp_served_user);
         end else begin
            oldest_word = pending_outcomes.pop_front();
            check_field("status", USER_W'(oldest_word.status), USER_W'(rsp_status));
            check_field("served_user", oldest_word.user, rsp_served_user);
            check_field("served_port", USER_W'(oldest_word.port), USER_W'(rsp_served_port));
            check_field("elapsed_ticks", oldest_word.ticks, rsp_elapsed_ticks);
            check_field("last", USER_W'(oldest_word.last), USER_W'(rsp_last));
         end
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_PORT_COUNT:     cfg_port_count = val[COUNT_W-1:0];
         CSR_SERVICE_TIME_0,
         CSR_SERVICE_TIME_1,
         CSR_SERVICE_TIME_2,
         CSR_SERVICE_TIME_3: cfg_service[idx - CSR_SERVICE_TIME_0] = val;
         default: ;
      endcase
   endtask

   task automatic configure(input int unsigned count, input int unsigned st0,
                            input int unsigned st1, input int unsigned st2,
                            input int unsigned st3);
      write_reg(CSR_PORT_COUNT, CSR_DATA_W'(count));
      write_reg(CSR_SERVICE_TIME_0, CSR_DATA_W'(st0));
      write_reg(CSR_SERVICE_TIME_1, CSR_DATA_W'(st1));
      write_reg(CSR_SERVICE_TIME_2, CSR_DATA_W'(st2));
      write_reg(CSR_SERVICE_TIME_3, CSR_DATA_W'(st3));
   endtask

   task automatic add_req(input req_kind_type kind, input int unsigned user,
                          input int unsigned port);
      server_req_type r;
      r.kind = kind;
      r.user = USER_W'(user);
      r.port = PORT_NUM_W'(port);
      queued_reqs.push_back(r);
      items_issued++;
   endtask

   // Fills one in-use port past its depth so the overflow words get dropped.
   task automatic flood_port();
      int unsigned p;
      p = $urandom_range(1, ports_in_use());
      repeat ($urandom_range(DEPTH + 1, DEPTH + 3)) add_req(REQ_ENQUEUE, $urandom, p);
   endtask

   // Mostly short enqueue runs followed by dequeues, with some noise mixed in.
   task automatic make_traffic(input int unsigned count);
      int unsigned start;
      int unsigned n;
      int unsigned pick;
      start = items_issued;
      n = ports_in_use();
      while (items_issued - start < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            repeat ($urandom_range(1, 4)) add_req(REQ_ENQUEUE, $urandom, $urandom_range(1, n));
            repeat ($urandom_range(1, 2))
               add_req(REQ_DEQUEUE, $urandom, $urandom_range(0, 7));
         end else if (pick < 75) begin
            repeat ($urandom_range(1, 3))
               add_req(REQ_DEQUEUE, $urandom, $urandom_range(0, 7));
         end else if (pick < 90) begin
            add_req(req_kind_type'($urandom_range(0, 1)), $urandom, $urandom_range(0, 7));
         end else begin
            add_req(REQ_ENQUEUE, $urandom,
                    ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(n + 1, 7));
         end
      end
   endtask

   // Waits for every word to be taken and answered, then lets the block settle.
   task automatic drain();
      while (!(items_taken == items_issued && pending_outcomes.size() == 0))
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      cfg_port_count = COUNT_W'(4);
      for (int i = 0; i < REG_PORTS; i++) cfg_service[i] = TICK_W'(1);
      for (int i = 0; i < PORTS; i++) begin
         head_of[i]    = 0;
         fill_of[i]    = 0;
         ticks_left[i] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: idle dequeue, bad ports, one user at every port
      // served together with the last mark on the final word.
      add_req(REQ_DEQUEUE, 16'h0000, 0);
      add_req(REQ_ENQUEUE, 16'hFFFF, 0);
      add_req(REQ_ENQUEUE, 16'h0000, 5);
      add_req(REQ_ENQUEUE, $urandom, 7);
      add_req(REQ_ENQUEUE, 16'hFFFF, 1);
      add_req(REQ_ENQUEUE, 16'h0000, 2);
      add_req(REQ_ENQUEUE, 16'hA5A5, 3);
      add_req(REQ_ENQUEUE, 16'h5A5A, 4);
      add_req(REQ_DEQUEUE, 16'hFFFF, 7);
      add_req(REQ_DEQUEUE, 16'h0000, 0);
      add_req(REQ_ENQUEUE, 16'h1234, 2);
      add_req(REQ_DEQUEUE, $urandom, 3);
      drain();

      // A port count of zero acts as one and a zero service time acts as one.
      configure(0, 0, 65535, 1, 7);
      for (int i = 32'(CSR_UNMAPPED_FIRST); i <= 32'(CSR_UNMAPPED_LAST); i++)
         write_reg(CSR_INDEX_W'(i), 16'hFFFF);
      add_req(REQ_ENQUEUE, 16'hBEEF, 2);
      add_req(REQ_ENQUEUE, 16'h00FF, 1);
      add_req(REQ_ENQUEUE, 16'hFF00, 1);
      add_req(REQ_DEQUEUE, $urandom, 0);
      add_req(REQ_DEQUEUE, $urandom, 0);
      make_traffic(11);
      drain();

      configure(4, 65535, 65535, 65535, 65535);
      flood_port();
      make_traffic(11);
      drain();

      // Ports three and four keep their contents while out of use.
      configure(2, 3, 5, $urandom_range(1, 65535), $urandom_range(1, 65535));
      make_traffic(11);
      drain();

      configure(7, 2, 3, 5, 7);
      flood_port();
      make_traffic(11);
      drain();

      configure(1, $urandom_range(1, 9), $urandom_range(1, 9), $urandom_range(1, 9),
                $urandom_range(1, 9));
      make_traffic(11);
      drain();

      configure(3, 1, 1, 2, 2);
      make_traffic(11);
      drain();

      configure(6, $urandom, $urandom, $urandom, $urandom);
      make_traffic(11);
      drain();

      configure(5, 1, 2, 3, 4);
      make_traffic(11);
      drain();

      if (failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("status: fail");
      $finish;
   end

endmodule
